// ----- design/egl_pkg.sv -----
// ----------------------------------------------------------------------------
// egl_pkg
// Shared types and constants for the Eagle 2x pixel upscaler.
// ----------------------------------------------------------------------------
package egl_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int PIXEL_BITS  = 32;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int COL_BITS    = 11;
    localparam int ROW_BITS    = 16;
    localparam int WREG_BITS   = 12;
    localparam int HREG_BITS   = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int OUT_BITS    = COL_BITS + ROW_BITS + 4 * PIXEL_BITS;
    localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [WREG_BITS-1:0] WIDTH_RESET  = 12'd256;
    localparam logic [HREG_BITS-1:0] HEIGHT_RESET = 16'd240;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } cfg_idx_t;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    // per-request bookkeeping carried alongside the line store read
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [COL_BITS-1:0]  col;
        logic [ROW_BITS-1:0]  row;
        logic                 has_result;
        logic                 last;
    } meta_t;

    typedef struct packed {
        pixel_t top_left;
        pixel_t top_right;
        pixel_t bottom_left;
        pixel_t bottom_right;
    } block_t;

endpackage

// ----- design/egl_line_store.sv -----
// ----------------------------------------------------------------------------
// egl_line_store
// Upper and middle line memories with registered read data.
// ----------------------------------------------------------------------------
module egl_line_store
    import egl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  pixel_t               wr_upper,
    input  pixel_t               wr_middle,
    output pixel_t               rd_upper,
    output pixel_t               rd_middle
);

    pixel_t upper_mem_reg  [MAX_WIDTH];
    pixel_t middle_mem_reg [MAX_WIDTH];
    pixel_t rd_upper_reg;
    pixel_t rd_middle_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem_reg[wr_addr]  <= wr_upper;
            middle_mem_reg[wr_addr] <= wr_middle;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_upper_reg  <= upper_mem_reg[rd_addr];
            rd_middle_reg <= middle_mem_reg[rd_addr];
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

// ----- design/egl_window.sv -----
// ----------------------------------------------------------------------------
// egl_window
// 3x3 window (two registered columns plus the incoming one) and the Eagle corner selection.
// ----------------------------------------------------------------------------
module egl_window
    import egl_pkg::*;
(
    input  logic   aclk,
    input  logic   shift_en,
    input  pixel_t col_top,
    input  pixel_t col_mid,
    input  pixel_t col_bot,
    output block_t blk
);

    // columns c-2 and c-1, rows top to bottom
    pixel_t s_reg, v_reg, x_reg;
    pixel_t t_reg, c_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            s_reg <= t_reg;
            v_reg <= c_reg;
            x_reg <= y_reg;
            t_reg <= col_top;
            c_reg <= col_mid;
            y_reg <= col_bot;
        end
    end

    always_comb begin
        blk.top_left     = (v_reg == s_reg && s_reg == t_reg) ? s_reg : c_reg;
        blk.top_right    = (t_reg == col_top && col_top == col_mid) ? col_top : c_reg;
        blk.bottom_left  = (v_reg == x_reg && x_reg == y_reg) ? x_reg : c_reg;
        blk.bottom_right = (col_mid == col_bot && col_bot == y_reg) ? col_bot : c_reg;
    end

endmodule

// ----- design/eagle_2x_pixel_upscaler.sv -----
// ----------------------------------------------------------------------------
// eagle_2x_pixel_upscaler
// Eagle 2x scaler: one 2x2 output block per interior input pixel.
// The block centred on (x,y) follows the request of pixel (x+1,y+1).
// Throughput: 1 pixel per cycle unless output stalls; 1 line store read+write each.
// Reset: synchronous active-low; counters clear, size 256x240, stores undefined.
// ----------------------------------------------------------------------------
module eagle_2x_pixel_upscaler
    import egl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [PIXEL_BITS-1:0]    s_tdata,   // pixel
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // center_col, center_row, top_left, top_right, bottom_left, bottom_right, zero pad
    output logic [OUT_BYTES_BITS-1:0] m_tdata,
    output logic                     m_tlast    // frame_last
);

    logic [WREG_BITS-1:0] width_reg,  width_next;
    logic [HREG_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0]  col_reg,    col_next;
    logic [ROW_BITS-1:0]  row_reg,    row_next;
    logic                 v1_reg,     v1_next;
    meta_t                meta_reg;
    pixel_t               bot_reg;
    logic                 mvalid_reg, mvalid_next;
    meta_t                mmeta_reg;
    block_t               mblk_reg;

    logic [WREG_BITS-1:0] w_eff;
    logic [HREG_BITS-1:0] h_eff;
    logic                 s_accept, adv1, out_free, col_wrap, row_wrap;
    pixel_t               rd_upper, rd_middle;
    block_t               blk;

    always_comb begin
        if (width_reg < WREG_BITS'(3)) begin
            w_eff = WREG_BITS'(3);
        end else if (width_reg > WREG_BITS'(MAX_WIDTH)) begin
            w_eff = WREG_BITS'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < HREG_BITS'(3)) ? HREG_BITS'(3) : height_reg;
    end

    assign out_free = !mvalid_reg || m_tready;
    assign adv1     = v1_reg && (!meta_reg.has_result || out_free);
    assign s_tready = !v1_reg || adv1;
    assign s_accept = s_tvalid && s_tready;

    assign col_wrap = ({1'b0, col_reg} + WREG_BITS'(1)) >= w_eff;
    assign row_wrap = ({1'b0, row_reg} + (ROW_BITS + 1)'(1)) >= {1'b0, h_eff};

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WIDTH: begin
                    width_next = cfg_data[WREG_BITS-1:0];
                    col_next   = '0;
                    row_next   = '0;
                end
                CFG_HEIGHT: begin
                    height_next = cfg_data[HREG_BITS-1:0];
                    col_next    = '0;
                    row_next    = '0;
                end
                default: begin
                end
            endcase
        end else if (s_accept) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_comb begin
        v1_next = s_accept ? 1'b1 : (adv1 ? 1'b0 : v1_reg);
        if (adv1 && meta_reg.has_result) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            v1_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            v1_reg     <= v1_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            bot_reg             <= s_tdata;
            meta_reg.addr       <= col_reg[ADDR_BITS-1:0];
            meta_reg.col        <= col_reg - COL_BITS'(1);
            meta_reg.row        <= row_reg - ROW_BITS'(1);
            meta_reg.has_result <= (row_reg >= ROW_BITS'(2)) && (col_reg >= COL_BITS'(2));
            meta_reg.last       <= col_wrap && row_wrap;
        end
        if (adv1 && meta_reg.has_result) begin
            mmeta_reg <= meta_reg;
            mblk_reg  <= blk;
        end
    end

    egl_line_store u_line_store (
        .aclk      (aclk),
        .rd_en     (s_accept),
        .rd_addr   (col_reg[ADDR_BITS-1:0]),
        .wr_en     (adv1),
        .wr_addr   (meta_reg.addr),
        .wr_upper  (rd_middle),
        .wr_middle (bot_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    egl_window u_window (
        .aclk     (aclk),
        .shift_en (adv1),
        .col_top  (rd_upper),
        .col_mid  (rd_middle),
        .col_bot  (bot_reg),
        .blk      (blk)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mmeta_reg.last;
    assign m_tdata  = {(OUT_BYTES_BITS - OUT_BITS)'(0),
                       mblk_reg.bottom_right, mblk_reg.bottom_left,
                       mblk_reg.top_right, mblk_reg.top_left,
                       mmeta_reg.row, mmeta_reg.col};

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        adv1 && meta_reg.has_result |=> mvalid_reg)
        else $error("result not registered");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)
        |=> col_reg == '0 && row_reg == '0)
        else $error("config write did not restart frame");

    a_col_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < w_eff)
        else $error("column counter beyond line width");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        mvalid_reg && !m_tready |-> !(adv1 && meta_reg.has_result))
        else $error("pending result overwritten");

endmodule

// ----- tb/sv/eagle_2x_block_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eagle_2x_block_checker
// Watches the configuration port and both stream channels of the Eagle 2x
// upscaler. Keeps its own line stores, window and counters, predicts the
// 2x2 block for every accepted pixel request that completes an interior
// window, and compares each delivered block field by field, in order.
// ----------------------------------------------------------------------------
module eagle_2x_block_checker
    import egl_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [PIXEL_BITS-1:0]     s_tdata,   // pixel
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // center_col, center_row, top_left, top_right, bottom_left, bottom_right, zero pad
    input  logic [OUT_BYTES_BITS-1:0] m_tdata,
    input  logic                      m_tlast,   // frame_last
    output int                        mismatch_count,
    output int                        blocks_pending
);

    localparam int ROW_LSB  = COL_BITS;
    localparam int TL_LSB   = ROW_LSB + ROW_BITS;
    localparam int TR_LSB   = TL_LSB + PIXEL_BITS;
    localparam int BL_LSB   = TR_LSB + PIXEL_BITS;
    localparam int BR_LSB   = BL_LSB + PIXEL_BITS;
    localparam int PAD_LSB  = BR_LSB + PIXEL_BITS;
    localparam int PAD_BITS = OUT_BYTES_BITS - OUT_BITS;

    typedef struct {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        block_t              px;
        logic                last;
    } scaled_block_t;

    scaled_block_t         blocks_due[$];
    pixel_t                upper_line  [MAX_WIDTH];
    pixel_t                middle_line [MAX_WIDTH];
    pixel_t                far_col     [3];   // column c-2: top, middle, bottom
    pixel_t                near_col    [3];   // column c-1
    logic [WREG_BITS-1:0]  width_reg;
    logic [HREG_BITS-1:0]  height_reg;
    int                    col_cnt;
    int                    row_cnt;
    int                    fail_total = 0;
    int                    due_count  = 0;

    assign mismatch_count = fail_total;
    assign blocks_pending = due_count;

    function automatic pixel_t eagle_pick(input pixel_t a, input pixel_t b, input pixel_t c,
                                          input pixel_t corner, input pixel_t centre);
        return (a == b && b == c) ? corner : centre;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_total < 100) begin
            $display("[%0t] block checker: %s", $time, msg);
        end
        fail_total++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
        end
    endtask

    always @(posedge aclk) begin : monitor
        int            w;
        int            h;
        pixel_t        top_px;
        pixel_t        mid_px;
        pixel_t        bot_px;
        scaled_block_t want;
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_cnt    = 0;
            row_cnt    = 0;
            blocks_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (blocks_due.size() == 0) begin
                    report_mismatch("block delivered with no request pending");
                end else begin
                    want = blocks_due.pop_front();
                    check_field("center_col", 32'(m_tdata[0 +: COL_BITS]), 32'(want.col));
                    check_field("center_row", 32'(m_tdata[ROW_LSB +: ROW_BITS]),
                                32'(want.row));
                    check_field("top_left", m_tdata[TL_LSB +: PIXEL_BITS], want.px.top_left);
                    check_field("top_right", m_tdata[TR_LSB +: PIXEL_BITS], want.px.top_right);
                    check_field("bottom_left", m_tdata[BL_LSB +: PIXEL_BITS],
                                want.px.bottom_left);
                    check_field("bottom_right", m_tdata[BR_LSB +: PIXEL_BITS],
                                want.px.bottom_right);
                    check_field("frame_last", 32'(m_tlast), 32'(want.last));
                    check_field("pad", 32'(m_tdata[PAD_LSB +: PAD_BITS]), 32'd0);
                end
            end

            // any write to a known register restarts the frame
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WIDTH: begin
                        width_reg = cfg_data[WREG_BITS-1:0];
                        col_cnt   = 0;
                        row_cnt   = 0;
                    end
                    CFG_HEIGHT: begin
                        height_reg = cfg_data[HREG_BITS-1:0];
                        col_cnt    = 0;
                        row_cnt    = 0;
                    end
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                w = int'(width_reg);
                if (w < 3) w = 3;
                if (w > MAX_WIDTH) w = MAX_WIDTH;
                h = int'(height_reg);
                if (h < 3) h = 3;
                top_px = upper_line[ADDR_BITS'(col_cnt)];
                mid_px = middle_line[ADDR_BITS'(col_cnt)];
                bot_px = s_tdata;
                if (row_cnt >= 2 && col_cnt >= 2) begin
                    want.col             = COL_BITS'(col_cnt - 1);
                    want.row             = ROW_BITS'(row_cnt - 1);
                    want.px.top_left     = eagle_pick(far_col[1], far_col[0], near_col[0],
                                                      far_col[0], near_col[1]);
                    want.px.top_right    = eagle_pick(near_col[0], top_px, mid_px,
                                                      top_px, near_col[1]);
                    want.px.bottom_left  = eagle_pick(far_col[1], far_col[2], near_col[2],
                                                      far_col[2], near_col[1]);
                    want.px.bottom_right = eagle_pick(mid_px, bot_px, near_col[2],
                                                      bot_px, near_col[1]);
                    want.last            = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
                    blocks_due.push_back(want);
                end
                upper_line[ADDR_BITS'(col_cnt)]  = mid_px;
                middle_line[ADDR_BITS'(col_cnt)] = bot_px;
                far_col              = near_col;
                near_col             = '{top_px, mid_px, bot_px};
                col_cnt++;
                if (col_cnt >= w) begin
                    col_cnt = 0;
                    row_cnt++;
                    if (row_cnt >= h) row_cnt = 0;
                end
            end
        end
        due_count <= blocks_due.size();
    end

endmodule

// ----- tb/sv/tb_eagle_2x_pixel_upscaler.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eagle_2x_pixel_upscaler
// Streams frames of pixels into the Eagle 2x upscaler under a series of
// frame sizes: a few hand-built 3x3 frames, an oversized line width, a tall
// frame, then random sizes with palette-based content so that the corner
// rules fire. Requests come in bursts, the block output stalls on its own
// pattern, and a separate checker predicts and compares every block.
// ----------------------------------------------------------------------------
module tb_eagle_2x_pixel_upscaler;
    import egl_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int WIDE_ITEMS   = 256;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 32;
    localparam int STALL_LIMIT  = 4000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index = CFG_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic [PIXEL_BITS-1:0]     s_tdata   = '0;
    logic                      m_tready  = 1'b0;
    wire                       s_tready;
    wire                       m_tvalid;
    wire  [OUT_BYTES_BITS-1:0] m_tdata;
    wire                       m_tlast;

    int                        mismatch_count;
    int                        blocks_pending;
    int                        quiet_cycles = 0;
    int                        burst_left   = 1;
    int                        palette_size = 2;
    int                        cur_width    = 256;
    int                        cur_height   = 240;
    bit                        steady_send  = 1'b0;
    bit                        hold_req     = 1'b0;
    pixel_t                    palette [4];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    eagle_2x_pixel_upscaler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    eagle_2x_block_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .blocks_pending (blocks_pending)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_eagle_2x_pixel_upscaler failed");
                $finish;
            end
        end
    end

    // output side: own stall pattern, plus one long hold-off on request
    initial begin : receiver
        rx_mode_t mode;
        int       stretch_left;
        int       beat;
        mode         = RX_OPEN;
        stretch_left = 0;
        beat         = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    mode         = rx_mode_t'($urandom_range(0, 3));
                    stretch_left = $urandom_range(16, 160);
                end
                stretch_left--;
                beat++;
                case (mode)
                    RX_OPEN:         m_tready <= 1'b1;
                    RX_COIN:         m_tready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: m_tready <= (beat % 4) != 0;
                    default:         m_tready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_WIDTH) cur_width = int'(val[WREG_BITS-1:0]);
        else if (idx == CFG_HEIGHT) cur_height = int'(val[HREG_BITS-1:0]);
    endtask

    task automatic push_pixel(input pixel_t px);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (burst_left <= 0 && !steady_send) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 48);
        end
    endtask

    // stop requesting and wait for every predicted block to arrive
    task automatic sync_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (blocks_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic new_palette();
        palette_size = $urandom_range(2, 4);
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 5) == 0) palette[i] = i[0] ? '1 : '0;
            else palette[i] = $urandom;
        end
    endtask

    task automatic stream_pixels(input int count);
        pixel_t px;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 6) == 0) px = $urandom;
            else px = palette[$urandom_range(0, palette_size - 1)];
            push_pixel(px);
            if ($urandom_range(0, 299) == 0) sync_idle();
        end
    endtask

    initial begin : stimulus
        pixel_t p;
        pixel_t q;
        pixel_t r;
        pixel_t frame_px [9];
        int     random_items;
        int     wval;
        int     hval;
        int     fw;
        int     fh;
        int     fp;
        int     n;
        random_items = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 3x3 frame, all neighbours equal and centre different: every corner taken
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd3);
        for (int i = 0; i < 9; i++) push_pixel(i == 4 ? 32'h0000_0000 : 32'hFFFF_FFFF);
        sync_idle();

        // undersized width and height act as 3x3; only top-left matches.
        // spare register index written mid-frame must not restart it
        write_reg(CFG_WIDTH, 16'd0);
        write_reg(CFG_HEIGHT, 16'd1);
        p        = $urandom;
        q        = ~p;
        r        = p ^ 32'h0000_FF00;
        frame_px = '{p, p, r, p, $urandom, r, q, q, $urandom};
        for (int i = 0; i < 4; i++) push_pixel(frame_px[i]);
        sync_idle();
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        for (int i = 4; i < 9; i++) push_pixel(frame_px[i]);
        sync_idle();

        // partial frame, cut short by the next size write
        for (int i = 0; i < 4; i++) push_pixel(frame_px[i]);
        sync_idle();

        // oversized width acts as full line store width: no wrap in the first line
        new_palette();
        write_reg(CFG_WIDTH, 16'h0FFF);
        write_reg(CFG_HEIGHT, 16'd3);
        stream_pixels(WIDE_ITEMS);
        sync_idle();

        // tallest frame, only its first rows
        write_reg(CFG_WIDTH, 16'd5);
        write_reg(CFG_HEIGHT, 16'hFFFF);
        stream_pixels(40);
        sync_idle();

        // output held off while requests keep coming
        new_palette();
        write_reg(CFG_WIDTH, 16'd16);
        write_reg(CFG_HEIGHT, 16'd8);
        hold_req    = 1'b1;
        steady_send = 1'b1;
        stream_pixels(200);
        steady_send = 1'b0;
        sync_idle();

        while (random_items < RANDOM_ITEMS) begin
            n = $urandom_range(0, 9);
            if (n < 8) wval = $urandom_range(3, 16);
            else if (n == 8) wval = $urandom_range(17, 40);
            else wval = $urandom_range(0, 2);
            hval = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            case ($urandom_range(0, 3))
                0: write_reg(CFG_WIDTH, {4'($urandom_range(0, 15)), 12'(wval)});
                1: write_reg(CFG_HEIGHT, 16'(hval));
                2: begin
                    write_reg(CFG_WIDTH, {4'($urandom_range(0, 15)), 12'(wval)});
                    write_reg(CFG_HEIGHT, 16'(hval));
                end
                default: begin
                    write_reg(CFG_HEIGHT, 16'(hval));
                    write_reg(CFG_WIDTH, {4'($urandom_range(0, 15)), 12'(wval)});
                end
            endcase
            if ($urandom_range(0, 5) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
            end
            fw = (cur_width < 3) ? 3 : cur_width;
            fh = (cur_height < 3) ? 3 : cur_height;
            fp = fw * fh;
            case ($urandom_range(0, 2))
                0:       n = fp * $urandom_range(1, 2);
                1:       n = fp * $urandom_range(1, 2) + $urandom_range(1, fp - 1);
                default: n = $urandom_range(1, fp - 1);
            endcase
            new_palette();
            steady_send = ($urandom_range(0, 4) == 0);
            stream_pixels(n);
            steady_send = 1'b0;
            sync_idle();
            random_items += n;
        end

        sync_idle();
        if (mismatch_count == 0) begin
            $display("tb_eagle_2x_pixel_upscaler passed");
        end else begin
            $display("tb_eagle_2x_pixel_upscaler failed");
        end
        $finish;
    end

endmodule
